// File: hdl/vfbc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vfbc_pkg;

  // stream and register port widths
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // field widths
  localparam int CH_W    = 3;
  localparam int TIME_W  = 32;
  localparam int FLOW_W  = 24;
  localparam int DRV_W   = 17;
  localparam int REG_W   = 16;

  // request kinds carried in tuser
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_RESET = 1'b1;

  // register indexes
  localparam logic [1:0] REG_MIN_OPEN  = 2'd0;
  localparam logic [1:0] REG_MIN_CLOSE = 2'd1;
  localparam logic [1:0] REG_MAX_DRIVE = 2'd2;
  localparam logic [1:0] REG_PERIOD    = 2'd3;

  // flow limits in raw q12.12 units (the two floors scaled by 500) and the minimum period
  localparam logic [27:0] HOLD_FLOOR  = 28'd102400;
  localparam logic [32:0] FULL_FLOOR  = 33'd204800;
  localparam logic [23:0] NOPULSE_MAX = 24'd4;
  localparam logic [15:0] PERIOD_MIN  = 16'd10;

  typedef enum logic [1:0] {
    LS_OFF        = 2'd0,
    LS_NO_PULSES  = 2'd1,
    LS_SATURATED  = 2'd2,
    LS_REGULATING = 2'd3
  } loop_status_t;

endpackage

`default_nettype wire

// File: hdl/valve_flow_band_controller_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | kind          | contents
// ---------+---------------+-----------------------------------------------
// in_      | stream slave  | tuser command, tdata channel/time/enable/flows
// out_     | stream master | tdata channel, drive, drive_written, status
// cfg_     | apb slave     | min_open, min_close, max_drive, period_ms
//
// reset, off or out-of-range requests go from S_ELAPSE to S_DONE, a step with
// the period not elapsed ends at S_DUE, an update inside the hold band skips to
// S_FIN, one outside it runs the 16-step restoring division in the subtractor
// in_tready is high only while the sequencer is idle; one finished result may
// wait in the output register while the next request is already taken
// rst_n is synchronous, sets the config registers to defaults and clears all channel state

module valve_flow_band_controller_core #(
  parameter int CHANNELS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input stream
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [2:0] channel, [34:3] now_ms, [35] flow_enabled, [59:36] target_flow,
  // [83:60] measured_flow, [87:84] zero
  input  wire logic [vfbc_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] command
  input  wire logic                            in_tuser,
  // result stream
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [2:0] out_channel, [19:3] drive, [20] drive_written, [22:21] loop_status,
  // [23] zero
  output logic [vfbc_pkg::OUT_DATA_W-1:0]      out_tdata,
  // config port
  input  wire logic                            cfg_psel,
  input  wire logic                            cfg_penable,
  input  wire logic                            cfg_pwrite,
  input  wire logic [vfbc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [vfbc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [vfbc_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                 cfg_pready
);

  import vfbc_pkg::*;

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ALU_W = 36;

  typedef enum logic [3:0] {
    S_IDLE, S_ELAPSE, S_DUE, S_SIGN, S_ABS, S_BAND, S_DEN, S_CLAMP,
    S_SPAN, S_SPAN2, S_MUL, S_DIV, S_FIN, S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // config registers
  logic [REG_W-1:0] min_open_r, min_open_nxt;
  logic [REG_W-1:0] min_close_r, min_close_nxt;
  logic [REG_W-1:0] max_drive_r, max_drive_nxt;
  logic [REG_W-1:0] period_r, period_nxt;

  // per-channel state
  logic [TIME_W-1:0] last_r   [CHANNELS];
  logic [DRV_W-1:0]  drive_st_r [CHANNELS];
  loop_status_t      status_st_r [CHANNELS];

  // latched request
  logic              cmd_r, cmd_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic              en_r, en_nxt;
  logic [FLOW_W-1:0] tgt_r, tgt_nxt;
  logic [FLOW_W-1:0] meas_r, meas_nxt;

  // working registers
  logic [TIME_W-1:0] elapsed_r, elapsed_nxt;
  logic              e_lt_r, e_lt_nxt;
  logic              e_pos_r, e_pos_nxt;
  logic [FLOW_W-1:0] ae_r, ae_nxt;
  logic [27:0]       hold_r, hold_nxt;
  logic [32:0]       full_r, full_nxt;
  logic [32:0]       num_r, num_nxt;
  logic [32:0]       den_r, den_nxt;
  logic              sat_r, sat_nxt;
  logic              inband_r, inband_nxt;
  logic [REG_W-1:0]  floor_r, floor_nxt;
  logic [REG_W-1:0]  span_r, span_nxt;
  logic              span_neg_r, span_neg_nxt;
  logic [32:0]       rem_r, rem_nxt;
  logic [15:0]       lo_r, lo_nxt;
  logic [15:0]       q_r, q_nxt;
  logic [3:0]        cnt_r, cnt_nxt;

  // result
  logic [DRV_W-1:0]  res_drive_r, res_drive_nxt;
  logic              res_written_r, res_written_nxt;
  loop_status_t      res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // channel store write controls
  logic              st_last_we, st_drive_we, st_status_we;
  logic [TIME_W-1:0] st_last_d;
  logic [DRV_W-1:0]  st_drive_d;
  loop_status_t      st_status_d;

  // shared add/subtract unit
  logic [ALU_W-1:0]  alu_a, alu_b;
  logic              alu_sub;
  logic [ALU_W:0]    alu_sum;
  logic [ALU_W-1:0]  alu_res;
  logic              alu_lt, alu_zero;

  logic [IDX_W-1:0]  idx;
  logic              ch_ok;
  logic [TIME_W-1:0] last_rd;
  logic [DRV_W-1:0]  drive_rd;
  loop_status_t      status_rd;
  logic [REG_W-1:0]  period_eff;
  logic [27:0]       t15;
  logic [32:0]       t500, ae500;
  logic [REG_W-1:0]  floor_sel;
  logic [33:0]       trial;
  logic [48:0]       prod;
  logic              nopulse;
  logic              cfg_wr;
  logic [DRV_W-1:0]  fin_drive;

  assign idx       = IDX_W'(ch_r);
  assign ch_ok     = (32'(ch_r) < CHANNELS);
  assign last_rd   = last_r[idx];
  assign drive_rd  = drive_st_r[idx];
  assign status_rd = status_st_r[idx];

  assign period_eff = (period_r < PERIOD_MIN) ? PERIOD_MIN : period_r;
  assign nopulse    = (meas_r <= NOPULSE_MAX);

  // constant scalings by shift and add: 15 = 16 - 1, 500 = 512 - 8 - 4
  assign t15   = ({4'd0, tgt_r} << 4) - {4'd0, tgt_r};
  assign t500  = ({9'd0, tgt_r} << 9) - ({9'd0, tgt_r} << 3) - ({9'd0, tgt_r} << 2);
  assign ae500 = ({9'd0, ae_r} << 9) - ({9'd0, ae_r} << 3) - ({9'd0, ae_r} << 2);

  assign floor_sel = e_pos_r ? min_open_r : min_close_r;
  assign trial     = {rem_r, lo_r[15]};
  assign prod      = num_r * span_r;

  assign alu_sum  = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                  + (ALU_W+1)'(alu_sub);
  assign alu_res  = alu_sum[ALU_W-1:0];
  assign alu_lt   = alu_sub & ~alu_sum[ALU_W];
  assign alu_zero = (alu_res == '0);

  // operand selection per step
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state_r)
      S_ELAPSE: begin
        alu_a = ALU_W'(now_r);
        alu_b = ALU_W'(last_rd);
      end
      S_DUE: begin
        alu_a = ALU_W'(elapsed_r);
        alu_b = ALU_W'(period_eff);
      end
      S_SIGN: begin
        alu_a = ALU_W'(tgt_r);
        alu_b = ALU_W'(meas_r);
      end
      S_ABS: begin
        alu_a = ALU_W'(e_lt_r ? meas_r : tgt_r);
        alu_b = ALU_W'(e_lt_r ? tgt_r : meas_r);
      end
      S_BAND: begin
        alu_a = ALU_W'(ae500);
        alu_b = ALU_W'(hold_r);
      end
      S_DEN: begin
        alu_a = ALU_W'(full_r);
        alu_b = ALU_W'(hold_r);
      end
      S_CLAMP: begin
        alu_a = ALU_W'(num_r);
        alu_b = ALU_W'(den_r);
      end
      S_SPAN: begin
        alu_a = ALU_W'(max_drive_r);
        alu_b = ALU_W'(floor_sel);
      end
      S_SPAN2: begin
        alu_a = ALU_W'(span_neg_r ? floor_r : max_drive_r);
        alu_b = ALU_W'(span_neg_r ? max_drive_r : floor_r);
      end
      S_DIV: begin
        alu_a = ALU_W'(trial);
        alu_b = ALU_W'(den_r);
      end
      S_FIN: begin
        // floor plus or minus the scaled span
        alu_a   = ALU_W'(floor_r);
        alu_b   = ALU_W'(q_r);
        alu_sub = span_neg_r;
      end
      default: begin
        alu_sub = 1'b1;
      end
    endcase
  end

  assign fin_drive = inband_r ? '0 :
                     (e_pos_r ? {1'b0, alu_res[REG_W-1:0]}
                              : DRV_W'(0) - {1'b0, alu_res[REG_W-1:0]});

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    ch_nxt          = ch_r;
    now_nxt         = now_r;
    en_nxt          = en_r;
    tgt_nxt         = tgt_r;
    meas_nxt        = meas_r;
    elapsed_nxt     = elapsed_r;
    e_lt_nxt        = e_lt_r;
    e_pos_nxt       = e_pos_r;
    ae_nxt          = ae_r;
    hold_nxt        = hold_r;
    full_nxt        = full_r;
    num_nxt         = num_r;
    den_nxt         = den_r;
    sat_nxt         = sat_r;
    inband_nxt      = inband_r;
    floor_nxt       = floor_r;
    span_nxt        = span_r;
    span_neg_nxt    = span_neg_r;
    rem_nxt         = rem_r;
    lo_nxt          = lo_r;
    q_nxt           = q_r;
    cnt_nxt         = cnt_r;
    res_drive_nxt   = res_drive_r;
    res_written_nxt = res_written_r;
    res_status_nxt  = res_status_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    st_last_we      = 1'b0;
    st_drive_we     = 1'b0;
    st_status_we    = 1'b0;
    st_last_d       = now_r;
    st_drive_d      = '0;
    st_status_d     = LS_OFF;

    // result taken downstream
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser;
          ch_nxt    = in_tdata[2:0];
          now_nxt   = in_tdata[34:3];
          en_nxt    = in_tdata[35];
          tgt_nxt   = in_tdata[59:36];
          meas_nxt  = in_tdata[83:60];
          state_nxt = S_ELAPSE;
        end
      end
      S_ELAPSE: begin
        elapsed_nxt     = alu_res[TIME_W-1:0];
        res_drive_nxt   = '0;
        res_written_nxt = 1'b0;
        res_status_nxt  = LS_OFF;
        priority if (!ch_ok) begin
          state_nxt = S_DONE;
        end else if (cmd_r == CMD_RESET) begin
          st_drive_we    = 1'b1;
          st_last_we     = 1'b1;
          res_status_nxt = status_rd;
          state_nxt      = S_DONE;
        end else if (!en_r || tgt_r == '0) begin
          // channel off
          st_drive_we     = 1'b1;
          st_status_we    = 1'b1;
          res_written_nxt = 1'b1;
          state_nxt       = S_DONE;
        end else begin
          // no-pulse mark applies whether or not an update is due
          if (nopulse) begin
            st_status_we = 1'b1;
            st_status_d  = LS_NO_PULSES;
          end
          state_nxt = S_DUE;
        end
      end
      S_DUE: begin
        if (alu_lt) begin
          res_drive_nxt  = drive_rd;
          res_status_nxt = status_rd;
          state_nxt      = S_DONE;
        end else begin
          st_last_we = 1'b1;
          hold_nxt   = (t15 < HOLD_FLOOR) ? HOLD_FLOOR : t15;
          full_nxt   = (t500 < FULL_FLOOR) ? FULL_FLOOR : t500;
          state_nxt  = S_SIGN;
        end
      end
      S_SIGN: begin
        e_lt_nxt  = alu_lt;
        e_pos_nxt = !alu_lt && !alu_zero;
        state_nxt = S_ABS;
      end
      S_ABS: begin
        ae_nxt    = alu_res[FLOW_W-1:0];
        state_nxt = S_BAND;
      end
      S_BAND: begin
        num_nxt    = alu_res[32:0];
        inband_nxt = alu_lt || alu_zero;
        sat_nxt    = 1'b0;
        state_nxt  = (alu_lt || alu_zero) ? S_FIN : S_DEN;
      end
      S_DEN: begin
        den_nxt   = alu_res[32:0];
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        if (!alu_lt) begin
          num_nxt = den_r;
          sat_nxt = 1'b1;
        end
        state_nxt = S_SPAN;
      end
      S_SPAN: begin
        floor_nxt    = floor_sel;
        span_neg_nxt = alu_lt;
        state_nxt    = S_SPAN2;
      end
      S_SPAN2: begin
        span_nxt  = alu_res[REG_W-1:0];
        state_nxt = S_MUL;
      end
      S_MUL: begin
        // quotient fits 16 bits since num never exceeds den
        rem_nxt   = prod[48:16];
        lo_nxt    = prod[15:0];
        q_nxt     = '0;
        cnt_nxt   = 4'd15;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (alu_lt) begin
          rem_nxt = trial[32:0];
        end else begin
          rem_nxt = alu_res[32:0];
        end
        q_nxt  = {q_r[14:0], !alu_lt};
        lo_nxt = {lo_r[14:0], 1'b0};
        cnt_nxt = cnt_r - 4'd1;
        if (cnt_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        st_drive_we  = 1'b1;
        st_drive_d   = fin_drive;
        st_status_we = 1'b1;
        priority if (nopulse) begin
          st_status_d = LS_NO_PULSES;
        end else if (sat_r) begin
          st_status_d = LS_SATURATED;
        end else begin
          st_status_d = LS_REGULATING;
        end
        res_drive_nxt   = fin_drive;
        res_written_nxt = 1'b1;
        res_status_nxt  = st_status_d;
        state_nxt       = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, res_status_r, res_written_r, res_drive_r, ch_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // config writes
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    min_open_nxt  = min_open_r;
    min_close_nxt = min_close_r;
    max_drive_nxt = max_drive_r;
    period_nxt    = period_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_MIN_OPEN:  min_open_nxt  = cfg_pwdata[REG_W-1:0];
        REG_MIN_CLOSE: min_close_nxt = cfg_pwdata[REG_W-1:0];
        REG_MAX_DRIVE: max_drive_nxt = cfg_pwdata[REG_W-1:0];
        REG_PERIOD:    period_nxt    = cfg_pwdata[REG_W-1:0];
        default:       period_nxt    = period_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MIN_OPEN:  cfg_prdata = CFG_DATA_W'(min_open_r);
      REG_MIN_CLOSE: cfg_prdata = CFG_DATA_W'(min_close_r);
      REG_MAX_DRIVE: cfg_prdata = CFG_DATA_W'(max_drive_r);
      REG_PERIOD:    cfg_prdata = CFG_DATA_W'(period_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    // datapath registers
    cmd_r         <= cmd_nxt;
    ch_r          <= ch_nxt;
    now_r         <= now_nxt;
    en_r          <= en_nxt;
    tgt_r         <= tgt_nxt;
    meas_r        <= meas_nxt;
    elapsed_r     <= elapsed_nxt;
    e_lt_r        <= e_lt_nxt;
    e_pos_r       <= e_pos_nxt;
    ae_r          <= ae_nxt;
    hold_r        <= hold_nxt;
    full_r        <= full_nxt;
    num_r         <= num_nxt;
    den_r         <= den_nxt;
    sat_r         <= sat_nxt;
    inband_r      <= inband_nxt;
    floor_r       <= floor_nxt;
    span_r        <= span_nxt;
    span_neg_r    <= span_neg_nxt;
    rem_r         <= rem_nxt;
    lo_r          <= lo_nxt;
    q_r           <= q_nxt;
    cnt_r         <= cnt_nxt;
    res_drive_r   <= res_drive_nxt;
    res_written_r <= res_written_nxt;
    res_status_r  <= res_status_nxt;
    out_data_r    <= out_data_nxt;

    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      min_open_r  <= '0;
      min_close_r <= '0;
      max_drive_r <= 16'hFFFF;
      period_r    <= PERIOD_MIN;
      for (int i = 0; i < CHANNELS; i++) begin
        last_r[i]      <= '0;
        drive_st_r[i]  <= '0;
        status_st_r[i] <= LS_OFF;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      min_open_r  <= min_open_nxt;
      min_close_r <= min_close_nxt;
      max_drive_r <= max_drive_nxt;
      period_r    <= period_nxt;
      if (st_last_we) begin
        last_r[idx] <= st_last_d;
      end
      if (st_drive_we) begin
        drive_st_r[idx] <= st_drive_d;
      end
      if (st_status_we) begin
        status_st_r[idx] <= st_status_d;
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_pready = 1'b1;

endmodule

`default_nettype wire

// File: hdl/vfbc_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module vfbc_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [vfbc_pkg::OUT_DATA_W-1:0] out_tdata
);

  import vfbc_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // requests taken but not yet answered
  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // one request in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input ready right after an accepted request");

  // no result without a pending request, never more than two in flight
  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != 2'd3) && (!out_tvalid || pend_r != 2'd0))
    else $error("result count does not match accepted requests");

  // an off channel never reports a drive
  a_off_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[22:21] == LS_OFF) |-> out_tdata[19:3] == '0)
    else $error("nonzero drive with status off");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind valve_flow_band_controller_core vfbc_checker u_vfbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
